@@ sv/snhm_pkg.sv @@
// Shared types, constants and helpers for the sensor node health monitor.
`default_nettype none
package snhm_pkg;

	localparam int STALE_LIMIT_DEF    = 3;
	localparam int DEADLINE_LIMIT_DEF = 3;
	localparam int OVERFLOW_LIMIT_DEF = 3;

	localparam int CNT_W  = 8;
	localparam int CHG_W  = 16;
	localparam int MEAS_W = 18;
	localparam int CFG_W  = 18;
	localparam int IDX_W  = 3;
	localparam int IN_W   = 48;
	localparam int OUT_W  = 40;

	typedef enum logic [1:0] {
		H_INIT    = 2'd0,
		H_HEALTHY = 2'd1,
		H_WARNING = 2'd2,
		H_FAULT   = 2'd3
	} health_t;

	typedef enum logic [1:0] {
		E_UNKNOWN   = 2'd0,
		E_NORMAL    = 2'd1,
		E_HIGH_TEMP = 2'd2,
		E_PRESSURE  = 2'd3
	} env_t;

	typedef enum logic [2:0] {
		C_NONE     = 3'd0,
		C_SENSOR   = 3'd1,
		C_STALE    = 3'd2,
		C_DEADLINE = 3'd3,
		C_OVERFLOW = 3'd4
	} cause_t;

	typedef enum logic [IDX_W-1:0] {
		R_SENSOR_FAIL_LIMIT   = 3'd0,
		R_RECOVERY_COUNT      = 3'd1,
		R_TEMP_HIGH_ENTER     = 3'd2,
		R_TEMP_HIGH_CLEAR     = 3'd3,
		R_PRESSURE_LOW_ENTER  = 3'd4,
		R_PRESSURE_HIGH_ENTER = 3'd5,
		R_PRESSURE_LOW_CLEAR  = 3'd6,
		R_PRESSURE_HIGH_CLEAR = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic               received;
		logic               valid;
		logic               stale;
		logic               missed_deadline;
		logic               queue_overflow;
		logic signed [MEAS_W-1:0] temperature_mc;
		logic [MEAS_W-1:0]  pressure_value;
	} sample_t;

	typedef struct packed {
		logic [CNT_W-1:0]         sensor_fail_limit;
		logic [CNT_W-1:0]         recovery_sample_count;
		logic signed [MEAS_W-1:0] temp_high_enter;
		logic signed [MEAS_W-1:0] temp_high_clear;
		logic [MEAS_W-1:0]        pressure_low_enter;
		logic [MEAS_W-1:0]        pressure_high_enter;
		logic [MEAS_W-1:0]        pressure_low_clear;
		logic [MEAS_W-1:0]        pressure_high_clear;
	} cfg_t;

	function automatic logic [CNT_W-1:0] sat_inc8(input logic [CNT_W-1:0] v);
		sat_inc8 = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

	function automatic logic [CHG_W-1:0] sat_inc16(input logic [CHG_W-1:0] v);
		sat_inc16 = (v == {CHG_W{1'b1}}) ? v : v + 1'b1;
	endfunction

endpackage
`default_nettype wire

@@ sv/sensor_node_health_monitor.sv @@
// Top level of the sensor node health monitor: stream ports, registers, input stage.
// One sample report in, one status result out, one item per clock cycle sustained
// while m_tready is high. A request is captured in the input register, then the health
// machine and the environmental status update together from it as it advances; the
// updated state registers form the result. The input stage accepts a new request
// while a result still waits, and stalls only when both are full.
// Configuration writes take effect at the next clock edge and should be made while idle.
`default_nettype none
module sensor_node_health_monitor #(
	parameter int STALE_LIMIT    = snhm_pkg::STALE_LIMIT_DEF,
	parameter int DEADLINE_LIMIT = snhm_pkg::DEADLINE_LIMIT_DEF,
	parameter int OVERFLOW_LIMIT = snhm_pkg::OVERFLOW_LIMIT_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// rx_flag, valid_flag, stale_flag, missed_deadline, queue_overflow,
	// temperature_mc[17:0], pressure_value[17:0], zero fill
	input  wire logic [snhm_pkg::IN_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// health_state[1:0], env_state[1:0], fault_cause[2:0], health_changes[15:0],
	// env_changes[15:0], zero fill
	output logic [snhm_pkg::OUT_W-1:0]        m_tdata,
	input  wire logic                         cfg_we,
	input  wire logic [snhm_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [snhm_pkg::CFG_W-1:0]   cfg_data
);

	snhm_pkg::cfg_t    cfg_q;
	snhm_pkg::sample_t sample_s1;
	logic              valid_s1;
	logic              out_valid_q;
	logic              advance;

	snhm_pkg::health_t          health_state;
	snhm_pkg::cause_t           fault_cause;
	snhm_pkg::env_t             env_state;
	logic [snhm_pkg::CHG_W-1:0] health_changes;
	logic [snhm_pkg::CHG_W-1:0] env_changes;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensor_fail_limit     <= 8'd3;
			cfg_q.recovery_sample_count <= 8'd5;
			cfg_q.temp_high_enter       <= 18'sd30000;
			cfg_q.temp_high_clear       <= 18'sd28000;
			cfg_q.pressure_low_enter    <= 18'd80000;
			cfg_q.pressure_high_enter   <= 18'd110000;
			cfg_q.pressure_low_clear    <= 18'd85000;
			cfg_q.pressure_high_clear   <= 18'd105000;
		end else if (cfg_we) begin
			case (snhm_pkg::reg_idx_t'(cfg_index))
				snhm_pkg::R_SENSOR_FAIL_LIMIT:   cfg_q.sensor_fail_limit <= cfg_data[7:0];
				snhm_pkg::R_RECOVERY_COUNT:      cfg_q.recovery_sample_count <= cfg_data[7:0];
				snhm_pkg::R_TEMP_HIGH_ENTER:     cfg_q.temp_high_enter <= cfg_data;
				snhm_pkg::R_TEMP_HIGH_CLEAR:     cfg_q.temp_high_clear <= cfg_data;
				snhm_pkg::R_PRESSURE_LOW_ENTER:  cfg_q.pressure_low_enter <= cfg_data;
				snhm_pkg::R_PRESSURE_HIGH_ENTER: cfg_q.pressure_high_enter <= cfg_data;
				snhm_pkg::R_PRESSURE_LOW_CLEAR:  cfg_q.pressure_low_clear <= cfg_data;
				snhm_pkg::R_PRESSURE_HIGH_CLEAR: cfg_q.pressure_high_clear <= cfg_data;
				default: ;
			endcase
		end
	end

	// the state registers double as the result register, so a request may only
	// move on once the previous result has gone
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (advance) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1.received        <= s_tdata[0];
			sample_s1.valid           <= s_tdata[1];
			sample_s1.stale           <= s_tdata[2];
			sample_s1.missed_deadline <= s_tdata[3];
			sample_s1.queue_overflow  <= s_tdata[4];
			sample_s1.temperature_mc  <= s_tdata[22:5];
			sample_s1.pressure_value  <= s_tdata[40:23];
		end
	end

	snhm_health #(
		.STALE_LIMIT    (STALE_LIMIT),
		.DEADLINE_LIMIT (DEADLINE_LIMIT),
		.OVERFLOW_LIMIT (OVERFLOW_LIMIT)
	) u_health (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.sample         (sample_s1),
		.cfg            (cfg_q),
		.health_state   (health_state),
		.fault_cause    (fault_cause),
		.health_changes (health_changes)
	);

	snhm_env u_env (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.sample      (sample_s1),
		.cfg         (cfg_q),
		.env_state   (env_state),
		.env_changes (env_changes)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, env_changes, health_changes, fault_cause, env_state, health_state};

endmodule
`default_nettype wire

@@ sv/snhm_health.sv @@
// Node health state machine with failure, clean-run and event counters.
`default_nettype none
module snhm_health #(
	parameter int STALE_LIMIT    = snhm_pkg::STALE_LIMIT_DEF,
	parameter int DEADLINE_LIMIT = snhm_pkg::DEADLINE_LIMIT_DEF,
	parameter int OVERFLOW_LIMIT = snhm_pkg::OVERFLOW_LIMIT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire snhm_pkg::sample_t             sample,
	input  wire snhm_pkg::cfg_t                cfg,
	output snhm_pkg::health_t                  health_state,
	output snhm_pkg::cause_t                   fault_cause,
	output logic [snhm_pkg::CHG_W-1:0]         health_changes
);

	localparam logic [snhm_pkg::CNT_W-1:0] STALE_LIM    = snhm_pkg::CNT_W'(STALE_LIMIT);
	localparam logic [snhm_pkg::CNT_W-1:0] DEADLINE_LIM = snhm_pkg::CNT_W'(DEADLINE_LIMIT);
	localparam logic [snhm_pkg::CNT_W-1:0] OVERFLOW_LIM = snhm_pkg::CNT_W'(OVERFLOW_LIMIT);

	snhm_pkg::health_t            health_q, health_d;
	snhm_pkg::cause_t             cause_q, cause_d;
	logic [snhm_pkg::CNT_W-1:0]   fail_q, fail_d;
	logic [snhm_pkg::CNT_W-1:0]   clean_q, clean_d;
	logic [snhm_pkg::CNT_W-1:0]   stale_q, stale_d;
	logic [snhm_pkg::CNT_W-1:0]   dl_q, dl_d;
	logic [snhm_pkg::CNT_W-1:0]   ov_q, ov_d;
	logic [snhm_pkg::CHG_W-1:0]   chg_q, chg_d;

	always_comb begin
		logic                       clean;
		logic                       go_healthy;
		logic [snhm_pkg::CNT_W-1:0] fail_n, clean_n, stale_n, dl_n, ov_n;
		snhm_pkg::cause_t           cause;

		clean   = sample.valid & ~sample.stale & ~sample.missed_deadline
			& ~sample.queue_overflow;
		fail_n  = sample.valid ? '0 : snhm_pkg::sat_inc8(fail_q);
		stale_n = sample.stale ? snhm_pkg::sat_inc8(stale_q) : stale_q;
		dl_n    = sample.missed_deadline ? snhm_pkg::sat_inc8(dl_q) : dl_q;
		ov_n    = sample.queue_overflow ? snhm_pkg::sat_inc8(ov_q) : ov_q;
		clean_n = clean ? snhm_pkg::sat_inc8(clean_q) : '0;

		// fixed priority: sensor failures first, overflows last
		if (fail_n >= cfg.sensor_fail_limit) begin
			cause = snhm_pkg::C_SENSOR;
		end else if (stale_n >= STALE_LIM) begin
			cause = snhm_pkg::C_STALE;
		end else if (dl_n >= DEADLINE_LIM) begin
			cause = snhm_pkg::C_DEADLINE;
		end else if (ov_n >= OVERFLOW_LIM) begin
			cause = snhm_pkg::C_OVERFLOW;
		end else begin
			cause = snhm_pkg::C_NONE;
		end

		health_d   = health_q;
		cause_d    = cause_q;
		go_healthy = 1'b0;

		if (cause != snhm_pkg::C_NONE) begin
			cause_d  = cause;
			health_d = snhm_pkg::H_FAULT;
		end else begin
			case (health_q)
				snhm_pkg::H_INIT: begin
					if (clean) go_healthy = 1'b1;
					else health_d = snhm_pkg::H_WARNING;
				end
				snhm_pkg::H_HEALTHY: begin
					if (!clean) health_d = snhm_pkg::H_WARNING;
				end
				default: begin
					if (clean && clean_n >= cfg.recovery_sample_count) go_healthy = 1'b1;
				end
			endcase
		end

		if (go_healthy) begin
			health_d = snhm_pkg::H_HEALTHY;
			fail_d   = '0;
			clean_d  = '0;
			stale_d  = '0;
			dl_d     = '0;
			ov_d     = '0;
		end else begin
			fail_d   = fail_n;
			clean_d  = clean_n;
			stale_d  = stale_n;
			dl_d     = dl_n;
			ov_d     = ov_n;
		end

		chg_d = (health_d != health_q) ? snhm_pkg::sat_inc16(chg_q) : chg_q;
	end

	// a report with no sample leaves the whole machine untouched
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			health_q <= snhm_pkg::H_INIT;
			cause_q  <= snhm_pkg::C_NONE;
			fail_q   <= '0;
			clean_q  <= '0;
			stale_q  <= '0;
			dl_q     <= '0;
			ov_q     <= '0;
			chg_q    <= '0;
		end else if (step && sample.received) begin
			health_q <= health_d;
			cause_q  <= cause_d;
			fail_q   <= fail_d;
			clean_q  <= clean_d;
			stale_q  <= stale_d;
			dl_q     <= dl_d;
			ov_q     <= ov_d;
			chg_q    <= chg_d;
		end
	end

	assign health_state   = health_q;
	assign fault_cause    = cause_q;
	assign health_changes = chg_q;

endmodule
`default_nettype wire

@@ sv/snhm_env.sv @@
// Environmental status with enter and clear hysteresis on temperature and pressure.
`default_nettype none
module snhm_env (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step,
	input  wire snhm_pkg::sample_t     sample,
	input  wire snhm_pkg::cfg_t        cfg,
	output snhm_pkg::env_t             env_state,
	output logic [snhm_pkg::CHG_W-1:0] env_changes
);

	snhm_pkg::env_t             env_q, env_d;
	logic [snhm_pkg::CHG_W-1:0] chg_q, chg_d;

	always_comb begin
		logic hot;
		logic press;

		hot = (sample.temperature_mc >= cfg.temp_high_enter)
			|| (env_q == snhm_pkg::E_HIGH_TEMP && sample.temperature_mc > cfg.temp_high_clear);
		press = (sample.pressure_value < cfg.pressure_low_enter)
			|| (sample.pressure_value > cfg.pressure_high_enter)
			|| (env_q == snhm_pkg::E_PRESSURE
				&& (sample.pressure_value < cfg.pressure_low_clear
					|| sample.pressure_value > cfg.pressure_high_clear));

		if (!sample.received || !sample.valid || sample.stale) begin
			env_d = snhm_pkg::E_UNKNOWN;
		end else if (hot) begin
			env_d = snhm_pkg::E_HIGH_TEMP;
		end else if (press) begin
			env_d = snhm_pkg::E_PRESSURE;
		end else begin
			env_d = snhm_pkg::E_NORMAL;
		end

		chg_d = (env_d != env_q) ? snhm_pkg::sat_inc16(chg_q) : chg_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q <= snhm_pkg::E_UNKNOWN;
			chg_q <= '0;
		end else if (step) begin
			env_q <= env_d;
			chg_q <= chg_d;
		end
	end

	assign env_state   = env_q;
	assign env_changes = chg_q;

endmodule
`default_nettype wire

@@ sv/snhm_checker.sv @@
// Port-level assertions for the sensor node health monitor, bound to the top level.
`default_nettype none
module snhm_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       m_tvalid,
	input wire logic                       m_tready,
	input wire logic [snhm_pkg::OUT_W-1:0] m_tdata
);

	// a stalled result holds still
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a fault always carries a reason
	a_fault_cause: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == snhm_pkg::H_FAULT |-> m_tdata[6:4] != snhm_pkg::C_NONE)
		else $error("fault without cause");

	// no health change counted means the machine never left initialising
	a_health_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[22:7] == '0 |-> m_tdata[1:0] == snhm_pkg::H_INIT)
		else $error("health state moved without a counted change");

	// likewise for the environmental status
	a_env_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[38:23] == '0 |-> m_tdata[3:2] == snhm_pkg::E_UNKNOWN)
		else $error("env state moved without a counted change");

endmodule

bind sensor_node_health_monitor snhm_checker u_snhm_checker (.*);
`default_nettype wire
